// ===== sv/pbb_pkg.sv =====
// ----------------------------------------------------------------------------
// pbb_pkg
// Shared types and constants for the packed ARGB bilinear blend.
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int unsigned TEXEL_W = 32;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned COEFF_W = 8;

  // lane masks for the two interleaved byte pairs
  localparam logic [TEXEL_W-1:0] LANE_MASK_HI = 32'hff00ff00;
  localparam logic [TEXEL_W-1:0] LANE_MASK_LO = 32'h00ff00ff;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // positions of the four texels in a quad
  localparam int unsigned TEX_TL = 0;
  localparam int unsigned TEX_TR = 1;
  localparam int unsigned TEX_BR = 2;
  localparam int unsigned TEX_BL = 3;

  typedef logic [3:0][TEXEL_W-1:0] pbb_quad_t;

  // per-stage advance enables for the weight pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pbb_adv_t;

endpackage

// ===== sv/pbb_if.sv =====
// ----------------------------------------------------------------------------
// pbb_in_if / pbb_out_if
// Valid/ready channels for texel quads in and blended colors out.
// ----------------------------------------------------------------------------
interface pbb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] texel_top_left;
  logic [31:0] texel_top_right;
  logic [31:0] texel_bottom_right;
  logic [31:0] texel_bottom_left;
  logic [7:0]  frac_x;
  logic [7:0]  frac_y;

  modport source (
    output valid, texel_top_left, texel_top_right, texel_bottom_right,
           texel_bottom_left, frac_x, frac_y,
    input  ready
  );
  modport sink (
    input  valid, texel_top_left, texel_top_right, texel_bottom_right,
           texel_bottom_left, frac_x, frac_y,
    output ready
  );
endinterface

interface pbb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] filtered_color;
  logic        is_opaque;

  modport source (output valid, filtered_color, is_opaque, input ready);
  modport sink (input valid, filtered_color, is_opaque, output ready);
endinterface

// ===== sv/pbb_coeff.sv =====
// ----------------------------------------------------------------------------
// pbb_coeff
// Three-stage fraction-to-weight unit: linear or smoothstep, scaled to 0..255.
// ----------------------------------------------------------------------------
module pbb_coeff
  import pbb_pkg::*;
(
  input  logic               clk,
  input  pbb_adv_t           adv,
  input  logic [FRAC_W-1:0]  frac,
  input  logic               cubic,
  output logic [COEFF_W-1:0] coeff
);

  logic [FRAC_W-1:0]  v1;
  logic [15:0]        sq1;
  logic               cubic1;
  logic [23:0]        num2;
  logic [23:0]        cube;
  logic [25:0]        num_wide;
  logic [31:0]        scaled;
  logic [COEFF_W-1:0] c_raw;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      v1     <= frac;
      sq1    <= {8'b0, frac} * {8'b0, frac};
      cubic1 <= cubic;
    end
  end

  // 768*f^2 - 2*f^3 stays below 2^24; linear mode puts f at bit 16
  always_comb begin
    cube     = {8'b0, sq1} * {16'b0, v1};
    num_wide = ({sq1, 9'b0} + {1'b0, sq1, 8'b0}) - {1'b0, cube, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      num2 <= cubic1 ? num_wide[23:0] : {v1, 16'b0};
    end
  end

  // floor(255 * num / 2^24), then fold bit 7 back in
  always_comb begin
    scaled = {num2, 8'b0} - {8'b0, num2};
    c_raw  = scaled[31:24];
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      coeff <= c_raw + {7'b0, c_raw[7]};
    end
  end

endmodule

// ===== sv/pbb_lerp.sv =====
// ----------------------------------------------------------------------------
// pbb_lerp
// One packed lerp lane: two byte channels under a lane mask.
// ----------------------------------------------------------------------------
module pbb_lerp
  import pbb_pkg::*;
(
  input  logic [TEXEL_W-1:0] mask,
  input  logic [COEFF_W-1:0] coeff,
  input  logic [TEXEL_W-1:0] from,
  input  logic [TEXEL_W-1:0] to,
  output logic [TEXEL_W-1:0] result
);

  logic [TEXEL_W-1:0]        a;
  logic [TEXEL_W-1:0]        b;
  logic signed [TEXEL_W:0]   diff;
  logic signed [COEFF_W:0]   coeff_s;
  logic signed [TEXEL_W+COEFF_W+1:0] prod;

  // signed packed difference; borrows between channels are kept on purpose
  always_comb begin
    a       = from & mask;
    b       = to & mask;
    diff    = $signed({1'b0, b}) - $signed({1'b0, a});
    coeff_s = $signed({1'b0, coeff});
    prod    = diff * coeff_s;
    result  = (a + prod[TEXEL_W+7:8]) & mask;
  end

endmodule

// ===== sv/packed_argb_bilinear_blend.sv =====
// ----------------------------------------------------------------------------
// packed_argb_bilinear_blend
// Bilinear ARGB8888 filter: weight pipeline, four x lanes, two y lanes, merge.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is ready; stages 1-3 hold
// the weight multipliers, stage 4 the four x lerp lanes, stage 5 the two y
// lanes and the merge.
// A stage that holds a word moves on only when the next stage frees up.
// Reset clears all stage valid bits and sets smooth_mode to linear.
module packed_argb_bilinear_blend
  import pbb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_data,
  pbb_in_if.sink    in_ch,
  pbb_out_if.source out_ch
);

  logic               smooth_mode;
  logic [5:1]         vld;
  logic [5:1]         adv;
  pbb_adv_t           wadv;
  pbb_quad_t          tex_in;
  pbb_quad_t          tex1;
  pbb_quad_t          tex2;
  pbb_quad_t          tex3;
  logic [COEFF_W-1:0] cx;
  logic [COEFF_W-1:0] cy;
  logic [COEFF_W-1:0] cy4;
  logic [TEXEL_W-1:0] top_h_c, top_l_c, bot_h_c, bot_l_c;
  logic [TEXEL_W-1:0] top_h, top_l, bot_h, bot_l;
  logic [TEXEL_W-1:0] res_h, res_l;
  logic [TEXEL_W-1:0] color;
  logic               opaque;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_mode <= 1'b0;
    end else if (cfg_write) begin
      smooth_mode <= cfg_data;
    end
  end

  // a stage advances when empty or when the next one advances
  always_comb begin
    adv[5] = !vld[5] || out_ch.ready;
    adv[4] = !vld[4] || adv[5];
    adv[3] = !vld[3] || adv[4];
    adv[2] = !vld[2] || adv[3];
    adv[1] = !vld[1] || adv[2];
    wadv   = '{s1: adv[1], s2: adv[2], s3: adv[3]};
  end

  assign in_ch.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= in_ch.valid;
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
      if (adv[4]) vld[4] <= vld[3];
      if (adv[5]) vld[5] <= vld[4];
    end
  end

  always_comb begin
    tex_in[TEX_TL] = in_ch.texel_top_left;
    tex_in[TEX_TR] = in_ch.texel_top_right;
    tex_in[TEX_BR] = in_ch.texel_bottom_right;
    tex_in[TEX_BL] = in_ch.texel_bottom_left;
  end

  // carry the texels alongside the weight pipeline
  always_ff @(posedge clk) begin
    if (adv[1]) tex1 <= tex_in;
    if (adv[2]) tex2 <= tex1;
    if (adv[3]) tex3 <= tex2;
  end

  pbb_coeff u_coeff_x (
    .clk   (clk),
    .adv   (wadv),
    .frac  (in_ch.frac_x),
    .cubic (smooth_mode),
    .coeff (cx)
  );

  pbb_coeff u_coeff_y (
    .clk   (clk),
    .adv   (wadv),
    .frac  (in_ch.frac_y),
    .cubic (smooth_mode),
    .coeff (cy)
  );

  pbb_lerp u_top_h (.mask(LANE_MASK_HI), .coeff(cx), .from(tex3[TEX_TL]),
                    .to(tex3[TEX_TR]), .result(top_h_c));
  pbb_lerp u_top_l (.mask(LANE_MASK_LO), .coeff(cx), .from(tex3[TEX_TL]),
                    .to(tex3[TEX_TR]), .result(top_l_c));
  pbb_lerp u_bot_h (.mask(LANE_MASK_HI), .coeff(cx), .from(tex3[TEX_BL]),
                    .to(tex3[TEX_BR]), .result(bot_h_c));
  pbb_lerp u_bot_l (.mask(LANE_MASK_LO), .coeff(cx), .from(tex3[TEX_BL]),
                    .to(tex3[TEX_BR]), .result(bot_l_c));

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      top_h <= top_h_c;
      top_l <= top_l_c;
      bot_h <= bot_h_c;
      bot_l <= bot_l_c;
      cy4   <= cy;
    end
  end

  pbb_lerp u_res_h (.mask(LANE_MASK_HI), .coeff(cy4), .from(top_h),
                    .to(bot_h), .result(res_h));
  pbb_lerp u_res_l (.mask(LANE_MASK_LO), .coeff(cy4), .from(top_l),
                    .to(bot_l), .result(res_l));

  // merge the two channel pairs
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      color  <= res_h | res_l;
      opaque <= (res_h[31:24] == ALPHA_OPAQUE);
    end
  end

  assign out_ch.valid          = vld[5];
  assign out_ch.filtered_color = color;
  assign out_ch.is_opaque      = opaque;

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && adv[5]) |=> vld[5])
    else $error("word lost between x lanes and output stage");

  a_opaque_flag: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (opaque == (color[31:24] == ALPHA_OPAQUE)))
    else $error("opaque flag disagrees with blended alpha");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (vld == 5'b11111))
    else $error("input stalled with a bubble in the pipeline");

  a_hold_x: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !adv[4]) |=> $stable(top_h) && $stable(cy4))
    else $error("x lane result changed while stalled");

endmodule
